// File: design/rsa_pkg.sv
`default_nettype none

package rsa_pkg;

    // Internal fixed point: signed Q.28 values
    localparam int QF = 28;

    localparam int TAU_FRAC_BITS_DEF    = 16;
    localparam int ALBEDO_FRAC_BITS_DEF = 16;

    typedef logic signed [33:0] t_q;

    localparam logic [28:0] ONE_Q = 29'd1 << QF;

    localparam longint LN2_L =
        (64'd6931471806 * (64'd1 << QF) + 64'd5000000000) / 64'd10000000000;
    localparam logic [33:0] LN2_Q = 34'(LN2_L);

    localparam longint C0_L = (64'd57721566 * (64'd1 << QF) + 64'd50000000) / 64'd100000000;
    localparam longint C1_L = (64'd99999193 * (64'd1 << QF) + 64'd50000000) / 64'd100000000;
    localparam longint C2_L = (64'd24991055 * (64'd1 << QF) + 64'd50000000) / 64'd100000000;
    localparam longint C3_L = (64'd5519968 * (64'd1 << QF) + 64'd50000000) / 64'd100000000;
    localparam longint C4_L = (64'd976004 * (64'd1 << QF) + 64'd50000000) / 64'd100000000;
    localparam longint C5_L = (64'd107857 * (64'd1 << QF) + 64'd50000000) / 64'd100000000;

    // E1 polynomial coefficients a0..a5
    localparam t_q POLY_Q [6] = '{
        -t_q'(C0_L), t_q'(C1_L), -t_q'(C2_L), t_q'(C3_L), -t_q'(C4_L), t_q'(C5_L)
    };

    // Q.28 product on magnitudes, truncated toward zero, sign applied after
    function automatic t_q mulq(t_q a, t_q b);
        logic [32:0] ua;
        logic [32:0] ub;
        logic [65:0] pr;
        logic [32:0] r;
        ua = a[33] ? 33'(-a) : a[32:0];
        ub = b[33] ? 33'(-b) : b[32:0];
        pr = {33'd0, ua} * {33'd0, ub};
        r  = pr[60:28];
        return (a[33] ^ b[33]) ? -t_q'({1'b0, r}) : t_q'({1'b0, r});
    endfunction

    function automatic t_q uq(logic [28:0] x);
        return t_q'({5'd0, x});
    endfunction

    // Exact floor(x / k) for x < 2^29, k <= 25, r = ceil(2^34 / k)
    function automatic logic [28:0] recip_mul(logic [28:0] x, logic [33:0] r);
        logic [62:0] pr;
        pr = {34'd0, x} * {29'd0, r};
        return pr[62:34];
    endfunction

endpackage

`default_nettype wire

// File: design/rsa_ifs.sv
`default_nettype none

interface rsa_tau_if import rsa_pkg::*; #(
    parameter int TAU_W = TAU_FRAC_BITS_DEF
);
    logic             valid;
    logic             ready;
    logic [TAU_W-1:0] tau;

    modport source (output valid, output tau, input ready);
    modport sink   (input valid, input tau, output ready);
endinterface

interface rsa_albedo_if import rsa_pkg::*; #(
    parameter int ALBEDO_W = ALBEDO_FRAC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [ALBEDO_W-1:0] albedo;

    modport source (output valid, output albedo, input ready);
    modport sink   (input valid, input albedo, output ready);
endinterface

`default_nettype wire

// File: design/rayleigh_spherical_albedo.sv
// Channel      Dir  Payload                              Handshake
// i_tau_ch     in   tau, unsigned Q0.TAU_FRAC_BITS       valid / ready
// o_albedo_ch  out  albedo, unsigned Q0.ALBEDO_FRAC_BITS valid / ready
//
// One item per cycle enters and leaves unless the output stalls. The depth is set
// by the ln path: 5 stages to normalize, a 28-step divider, 14 stages of atanh
// series, 6 stages to form E3 and the numerator, an integer step, one quotient
// bit per stage and the output stage. The 26 stages of the e^-t series run
// alongside.
// The pipeline freezes as a whole while the output holds a result not taken.
// Reset (synchronous, i_rst_n low) clears the valid bits only.
`default_nettype none

module rayleigh_spherical_albedo import rsa_pkg::*; #(
    parameter int TAU_FRAC_BITS    = TAU_FRAC_BITS_DEF,
    parameter int ALBEDO_FRAC_BITS = ALBEDO_FRAC_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    rsa_tau_if.sink      i_tau_ch,
    rsa_albedo_if.source o_albedo_ch
);

    localparam int A    = ALBEDO_FRAC_BITS;
    localparam int LAST = 55 + A;

    typedef struct packed {
        logic [27:0]  t;
        logic         zero;
        logic [28:0]  term;
        logic [28:0]  ex;
        logic [28:0]  pw;
        t_q           poly;
        logic [28:0]  tt;
        logic [28:0]  m;
        logic [4:0]   e;
        logic [29:0]  dr;
        logic [29:0]  dd;
        logic [27:0]  z;
        logic [27:0]  z2;
        logic [27:0]  p;
        logic [28:0]  s;
        t_q           nl;
        t_q           esum;
        t_q           tail;
        logic [28:0]  exq;
        t_q           e3;
        t_q           m3;
        t_q           num;
        logic [30:0]  den;
        logic [29:0]  h;
        logic [30:0]  qr;
        logic [A-1:0] q;
        logic         sat;
        logic         neg;
        logic [A-1:0] albedo;
    } t_stage;

    t_stage        r_p [0:LAST];
    t_stage        n_p [0:LAST];
    logic [LAST:0] r_vld;
    logic          w_en;

    assign w_en           = !r_vld[LAST] || o_albedo_ch.ready;
    assign i_tau_ch.ready = w_en;

    always_comb begin
        n_p[0]      = '0;
        n_p[0].t    = {i_tau_ch.tau, {(QF - TAU_FRAC_BITS){1'b0}}};
        n_p[0].zero = (i_tau_ch.tau == '0);
        n_p[0].term = ONE_Q;
        n_p[0].ex   = ONE_Q;
        n_p[0].pw   = ONE_Q;
        n_p[0].poly = POLY_Q[0];
        n_p[0].m    = {1'b0, n_p[0].t};
    end

    for (genvar j = 1; j <= LAST; j++) begin : g_st
        localparam int          EK = (j + 1) / 2;
        localparam logic [33:0] ER = (EK >= 2) ?
            34'(((64'd1 << 34) + 64'(EK) - 64'd1) / 64'(EK)) : 34'd0;
        localparam int          LK = (j >= 36) ? 2 * (j - 35) + 1 : 3;
        localparam logic [33:0] LR = 34'(((64'd1 << 34) + 64'(LK) - 64'd1) / 64'(LK));
        localparam int          SH = (j <= 5) ? (16 >> (j - 1)) : 1;
        localparam int          PI = (j >= 2 && j <= 6) ? j - 1 : 1;
        localparam int          HB = (j >= 55 && j <= 54 + A) ? A - 1 - (j - 55) : 0;

        logic [30:0] w_rr;
        logic [31:0] w_qq;
        logic [34:0] w_hi;
        t_q          w_x;
        logic [30:0] w_w;
        logic [33:0] w_el;

        always_comb begin
            n_p[j] = r_p[j-1];
            w_rr   = '0;
            w_qq   = '0;
            w_hi   = '0;
            w_x    = '0;
            w_w    = '0;
            w_el   = '0;

            // e^-t: multiply by t, then divide by k and accumulate
            if (j <= 26) begin
                if (j % 2 == 1) begin
                    n_p[j].term = 29'(mulq(uq(r_p[j-1].term), uq({1'b0, r_p[j-1].t})));
                end else begin
                    n_p[j].term = (EK == 1) ? r_p[j-1].term : recip_mul(r_p[j-1].term, ER);
                    n_p[j].ex   = (EK % 2 == 1) ? r_p[j-1].ex - n_p[j].term
                                                : r_p[j-1].ex + n_p[j].term;
                end
            end
            if (j == 27) begin
                n_p[j].exq = 29'(mulq(uq(r_p[j-1].ex), uq(ONE_Q - {1'b0, r_p[j-1].t})));
            end

            // Polynomial: next power and one coefficient term per stage
            if (j == 1) begin
                n_p[j].pw = 29'(mulq(uq(r_p[j-1].pw), uq({1'b0, r_p[j-1].t})));
                n_p[j].tt = 29'(mulq(uq({1'b0, r_p[j-1].t}), uq({1'b0, r_p[j-1].t})));
            end
            if (j >= 2 && j <= 6) begin
                n_p[j].poly = r_p[j-1].poly + mulq(POLY_Q[PI], uq(r_p[j-1].pw));
                n_p[j].pw   = 29'(mulq(uq(r_p[j-1].pw), uq({1'b0, r_p[j-1].t})));
            end

            // Normalize m into [1,2)
            if (j <= 5) begin
                if (r_p[j-1].m[28 -: SH] == '0) begin
                    n_p[j].m = r_p[j-1].m << SH;
                    n_p[j].e = r_p[j-1].e + 5'(SH);
                end
                if (j == 5) begin
                    n_p[j].dr = 30'(n_p[j].m) - 30'(ONE_Q);
                    n_p[j].dd = 30'(n_p[j].m) + 30'(ONE_Q);
                end
            end

            // z = (m-1)/(m+1), one quotient bit per stage
            if (j >= 6 && j <= 33) begin
                w_rr = {r_p[j-1].dr, 1'b0};
                if (w_rr >= {1'b0, r_p[j-1].dd}) begin
                    n_p[j].dr = 30'(w_rr - {1'b0, r_p[j-1].dd});
                    n_p[j].z  = {r_p[j-1].z[26:0], 1'b1};
                end else begin
                    n_p[j].dr = w_rr[29:0];
                    n_p[j].z  = {r_p[j-1].z[26:0], 1'b0};
                end
            end

            // atanh series: odd powers of z, each over its index
            if (j == 34) begin
                n_p[j].z2 = 28'(mulq(uq({1'b0, r_p[j-1].z}), uq({1'b0, r_p[j-1].z})));
                n_p[j].p  = r_p[j-1].z;
                n_p[j].s  = {1'b0, r_p[j-1].z};
            end
            if (j >= 35 && j <= 46) begin
                n_p[j].p = 28'(mulq(uq({1'b0, r_p[j-1].p}), uq({1'b0, r_p[j-1].z2})));
            end
            if (j >= 36 && j <= 47) begin
                n_p[j].s = r_p[j-1].s + recip_mul({1'b0, r_p[j-1].p}, LR);
            end
            if (j == 48) begin
                w_el        = 34'(r_p[j-1].e) * LN2_Q;
                n_p[j].nl   = t_q'(w_el) - t_q'({4'd0, r_p[j-1].s, 1'b0});
            end
            if (j == 49) begin
                n_p[j].esum = r_p[j-1].poly + r_p[j-1].nl;
            end
            if (j == 50) begin
                n_p[j].tail = r_p[j-1].zero ? '0 : mulq(uq(r_p[j-1].tt), r_p[j-1].esum);
            end

            // E3, then numerator and denominator
            if (j == 51) begin
                w_x        = uq(r_p[j-1].exq) + r_p[j-1].tail;
                n_p[j].e3  = (w_x + t_q'({33'd0, w_x[33]})) >>> 1;
            end
            if (j == 52) begin
                w_w       = 31'(ONE_Q) * 31'd4 + {2'd0, r_p[j-1].t, 1'b0};
                n_p[j].m3 = mulq(r_p[j-1].e3, t_q'({3'd0, w_w}));
            end
            if (j == 53) begin
                n_p[j].num = uq({1'b0, r_p[j-1].t}) + uq({r_p[j-1].t, 1'b0})
                           - r_p[j-1].m3 + t_q'({4'd0, r_p[j-1].ex, 1'b0});
                n_p[j].den = 31'(ONE_Q) * 31'd4 + {3'd0, r_p[j-1].t}
                           + {2'd0, r_p[j-1].t, 1'b0};
                n_p[j].h   = n_p[j].den[30:1];
            end

            // Rounded quotient: integer part first, then one bit per stage
            if (j == 54) begin
                w_hi       = {2'd0, r_p[j-1].num[32:0]} + 35'(r_p[j-1].h >> A);
                n_p[j].neg = (r_p[j-1].num <= 0);
                n_p[j].sat = !n_p[j].neg && (w_hi >= {4'd0, r_p[j-1].den});
                n_p[j].qr  = w_hi[30:0];
                n_p[j].q   = '0;
            end
            if (j >= 55 && j <= 54 + A) begin
                w_qq = {r_p[j-1].qr, r_p[j-1].h[HB]};
                if (w_qq >= {1'b0, r_p[j-1].den}) begin
                    n_p[j].qr = 31'(w_qq - {1'b0, r_p[j-1].den});
                    n_p[j].q  = {r_p[j-1].q[A-2:0], 1'b1};
                end else begin
                    n_p[j].qr = w_qq[30:0];
                    n_p[j].q  = {r_p[j-1].q[A-2:0], 1'b0};
                end
            end
            if (j == LAST) begin
                n_p[j].albedo = r_p[j-1].neg ? '0 : (r_p[j-1].sat ? '1 : r_p[j-1].q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], i_tau_ch.valid};
        end
    end

    // Advance all stages together; hold everything on a stall
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k <= LAST; k++) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    assign o_albedo_ch.valid  = r_vld[LAST];
    assign o_albedo_ch.albedo = r_p[LAST].albedo;

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_albedo_ch.valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] |-> !(r_p[LAST].sat && r_p[LAST].neg))
        else $error("saturate and negative both set");

    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] && r_p[LAST].zero |-> o_albedo_ch.albedo == '0)
        else $error("zero depth gave nonzero albedo");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import rsa_pkg::*;

    localparam int TAU_W = TAU_FRAC_BITS_DEF;
    localparam int ALB_W = ALBEDO_FRAC_BITS_DEF;
    localparam int LATENCY = 55 + ALB_W;
    localparam int N_RANDOM = 950;
    localparam longint CYCLE_LIMIT = 400000;

    localparam longint Q_ONE = longint'(1) << QF;
    localparam longint Q_LN2 = (64'd6931471806 * Q_ONE + 64'd5000000000) / 64'd10000000000;

    // E1 polynomial coefficients, value * 2^28 rounded to nearest
    function automatic longint coef_q(longint m);
        return (m * Q_ONE + 64'd50000000) / 64'd100000000;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        bit neg;
        longint unsigned ua;
        longint unsigned ub;
        longint r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r = longint'((ua * ub) >> QF);
        return neg ? -r : r;
    endfunction

    function automatic longint exp_neg_q(longint unsigned t);
        longint sum;
        longint unsigned term;
        sum = Q_ONE;
        term = Q_ONE;
        for (int k = 1; k <= 13; k++) begin
            term = ((term * t) >> QF) / k;
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        return sum;
    endfunction

    function automatic longint neg_log_q(longint unsigned t);
        longint unsigned m;
        longint e;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned p;
        longint unsigned s;
        m = t;
        e = 0;
        while (m < Q_ONE) begin
            m = m << 1;
            e++;
        end
        z = ((m - Q_ONE) << QF) / (m + Q_ONE);
        z2 = (z * z) >> QF;
        p = z;
        s = z;
        for (int k = 1; k <= 12; k++) begin
            p = (p * z2) >> QF;
            s += p / (2 * k + 1);
        end
        return e * Q_LN2 - longint'(2 * s);
    endfunction

    function automatic logic [ALB_W-1:0] spherical_albedo(logic [TAU_W-1:0] tau);
        longint t;
        longint ex;
        longint tail;
        longint e3;
        longint num;
        longint den;
        longint q;
        longint poly;
        longint pw;
        longint coefs [6];
        coefs[0] = -coef_q(57721566);
        coefs[1] = coef_q(99999193);
        coefs[2] = -coef_q(24991055);
        coefs[3] = coef_q(5519968);
        coefs[4] = -coef_q(976004);
        coefs[5] = coef_q(107857);
        t = longint'(tau) << (QF - TAU_W);
        ex = exp_neg_q(t);
        tail = 0;
        if (t != 0) begin
            poly = coefs[0];
            pw = Q_ONE;
            for (int i = 1; i <= 5; i++) begin
                pw = fx_mul(pw, t);
                poly += fx_mul(coefs[i], pw);
            end
            tail = fx_mul(fx_mul(t, t), poly + neg_log_q(t));
        end
        e3 = (fx_mul(ex, Q_ONE - t) + tail) / 2;
        num = 3 * t - fx_mul(e3, 4 * Q_ONE + 2 * t) + 2 * ex;
        den = 4 * Q_ONE + 3 * t;
        if (num <= 0) q = 0;
        else begin
            q = longint'(((longint'(num) << ALB_W) + den / 2) / den);
            if (q > (longint'(1) << ALB_W) - 1) q = (longint'(1) << ALB_W) - 1;
        end
        return q[ALB_W-1:0];
    endfunction

    class albedo_scoreboard;
        logic [ALB_W-1:0] pending [$];
        int mismatches;

        function void note_tau(logic [TAU_W-1:0] tau);
            pending.push_back(spherical_albedo(tau));
        endfunction

        function void check_albedo(logic [ALB_W-1:0] got);
            logic [ALB_W-1:0] want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected albedo %0d", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("albedo mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    longint cycles = 0;
    bit no_idle;
    albedo_scoreboard sb;

    rsa_tau_if #(.TAU_W(TAU_W)) tau_ch ();
    rsa_albedo_if #(.ALBEDO_W(ALB_W)) albedo_ch ();

    rayleigh_spherical_albedo DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tau_ch   (tau_ch.sink),
        .o_albedo_ch(albedo_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic bit take_break();
        return !no_idle && ($urandom_range(99) < 27);
    endfunction

    // Present one tau and hold it until the transfer; drop valid only while idling
    task automatic send_tau(logic [TAU_W-1:0] tau);
        while (take_break()) begin
            tau_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        tau_ch.valid <= 1'b1;
        tau_ch.tau <= tau;
        do @(posedge i_clk); while (!tau_ch.ready);
        sb.note_tau(tau);
        @(negedge i_clk);
    endtask

    task automatic drain();
        tau_ch.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending.size() != 0);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && albedo_ch.valid && albedo_ch.ready) sb.check_albedo(albedo_ch.albedo);
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) albedo_ch.ready <= 1'b0;
        else albedo_ch.ready <= !take_break();
    end

    initial begin
        logic [TAU_W-1:0] directed [$];
        sb = new();
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        tau_ch.valid = 1'b0;
        tau_ch.tau = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero depth, extremes, single bits, alternating patterns
        directed = {16'h0000, 16'h0001, 16'h0002, 16'hFFFF, 16'hFFFE, 16'h8000,
                    16'h7FFF, 16'h5555, 16'hAAAA, 16'h0100, 16'h0010, 16'h4000,
                    16'h2000, 16'h00FF, 16'hFF00, 16'h0000};
        foreach (directed[i]) send_tau(directed[i]);
        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            no_idle = (n >= 300 && n < 450);
            if (n == 600) drain();
            case ($urandom_range(3))
                0: send_tau(TAU_W'($urandom_range(255)));
                default: send_tau(TAU_W'($urandom()));
            endcase
        end
        no_idle = 1'b0;
        drain();
        repeat (LATENCY + 20) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: sim.f
design/rsa_pkg.sv
design/rsa_ifs.sv
design/rayleigh_spherical_albedo.sv
tb/tb.sv
